// File: src/wah_pkg.sv
// Shared types, constants and the cosine table function for the window block.
`timescale 1ns / 1ps
`default_nettype none

package wah_pkg;

  // Frame, sample and table sizes
  localparam int MAX_LENGTH      = 1024;
  localparam int SAMPLE_BITS     = 16;
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int COS_ADDR_BITS   = $clog2(COS_TABLE_DEPTH);

  localparam int LEN_W   = 11;
  localparam int IDX_W   = 10;
  localparam int DIVR_W  = IDX_W;     // length-1 is at most MAX_LENGTH-1
  localparam int STEP_W  = 24;
  localparam int QUOT_W  = STEP_W + 1;
  localparam int QCNT_W  = $clog2(QUOT_W);
  localparam int COS_W   = 16;
  localparam int COEF_W  = 17;        // unsigned Q0.16, up to 1.0 inclusive
  localparam int GAIN_W  = 16;        // unsigned Q2.14
  localparam int PROD_W  = SAMPLE_BITS + COEF_W - 1;
  localparam int TOTAL_W = PROD_W + GAIN_W;
  localparam int RES_SH  = 30;
  localparam int RES_W   = TOTAL_W - RES_SH;

  // Register indexes of the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KIND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORR   = 2'd2;
  localparam int CFG_DATA_W = LEN_W;

  // Window kinds
  localparam logic KIND_HANN    = 1'b0;
  localparam logic KIND_HAMMING = 1'b1;

  // Coefficient and gain constants
  localparam logic [15:0] HAMMING_B       = 16'd30147;
  localparam logic [GAIN_W-1:0] GAIN_UNITY   = 16'd16384;
  localparam logic [GAIN_W-1:0] GAIN_HANN    = 16'd32768;
  localparam logic [GAIN_W-1:0] GAIN_HAMMING = 16'd30343;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LENGTH);
  localparam int STEP_RESET_INT = ((1 << STEP_W) + (MAX_LENGTH - 1) / 2) / (MAX_LENGTH - 1);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(STEP_RESET_INT);
  localparam logic [STEP_W-1:0] STEP_MAX   = '1;

  // Settings seen by the datapath
  typedef struct packed {
    logic              kind;
    logic              corr;
    logic [STEP_W-1:0] angle_step;
  } cfg_t;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // cos of (pi/2)*r/depth in Q30, Taylor series through x^16
  function automatic longint unsigned cos_quad_q30(longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned prd;
    longint unsigned sub;
    x  = HALF_PI_Q30 * r / COS_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int n = 8; n >= 1; n--) begin
      prd = (x2 * t) >> 30;
      // divide by (2n-1)*2n for this term
      case (n)
        8:       sub = prd / 64'd240;
        7:       sub = prd / 64'd182;
        6:       sub = prd / 64'd132;
        5:       sub = prd / 64'd90;
        4:       sub = prd / 64'd56;
        3:       sub = prd / 64'd30;
        2:       sub = prd / 64'd12;
        default: sub = prd >> 1;
      endcase
      t   = (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
    end
    return t;
  endfunction

  function automatic longint unsigned q30_to_q15(longint unsigned v);
    longint unsigned q;
    q = (v + (64'd1 << 14)) >> 15;
    return (q > 64'd32767) ? 64'd32767 : q;
  endfunction

  // One entry of the full-turn cosine table, Q1.15
  function automatic logic signed [COS_W-1:0] cos_entry(int k);
    longint unsigned quad;
    longint unsigned r;
    longint unsigned c;
    longint unsigned s;
    logic signed [COS_W-1:0] v;
    quad = (4 * longint'(k)) / COS_TABLE_DEPTH;
    r    = 4 * longint'(k) - quad * COS_TABLE_DEPTH;
    c    = q30_to_q15(cos_quad_q30(r));
    s    = q30_to_q15(cos_quad_q30(COS_TABLE_DEPTH - r));
    case (quad)
      64'd0:   v = COS_W'(c);
      64'd1:   v = -COS_W'(s);
      64'd2:   v = -COS_W'(c);
      default: v = COS_W'(s);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/wah_if.sv
// Valid/ready channel interfaces for input samples and windowed results.
`timescale 1ns / 1ps
`default_nettype none

interface wah_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [wah_pkg::SAMPLE_BITS-1:0] sample;
  logic        [wah_pkg::IDX_W-1:0]       sample_index;

  modport source (output valid, output sample, output sample_index, input ready);
  modport sink   (input valid, input sample, input sample_index, output ready);
endinterface

interface wah_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [wah_pkg::SAMPLE_BITS-1:0] windowed_sample;
  logic                                   overflow;

  modport source (output valid, output windowed_sample, output overflow, input ready);
  modport sink   (input valid, input windowed_sample, input overflow, output ready);
endinterface

`default_nettype wire

// File: src/wah_cfg.sv
// Configuration registers and the serial divider that derives the angle step.
`timescale 1ns / 1ps
`default_nettype none

module wah_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [wah_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wah_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output wah_pkg::cfg_t                         cfg,
  output logic                                  busy
);

  wah_pkg::div_state_t state_r, state_nxt;

  logic                              kind_r;
  logic                              corr_r;
  logic [wah_pkg::STEP_W-1:0]        step_r, step_nxt;
  logic [wah_pkg::DIVR_W-1:0]        dvs_r, dvs_nxt;
  logic [wah_pkg::DIVR_W-1:0]        rem_r, rem_nxt;
  logic [wah_pkg::QUOT_W-1:0]        num_r, num_nxt;
  logic [wah_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;

  logic                              start;
  logic                              last;
  logic [wah_pkg::LEN_W-1:0]         len_eff;
  logic [wah_pkg::LEN_W-1:0]         len_m1;
  logic [wah_pkg::DIVR_W:0]          trial;
  logic                              ge;
  logic [wah_pkg::QUOT_W-1:0]        quot;

  assign start = cfg_we && (cfg_index == wah_pkg::REG_LENGTH);

  // Clamp the length into 2..MAX_LENGTH
  always_comb begin
    if (cfg_wdata < wah_pkg::LEN_W'(2)) begin
      len_eff = wah_pkg::LEN_W'(2);
    end else if (cfg_wdata > wah_pkg::LEN_W'(wah_pkg::MAX_LENGTH)) begin
      len_eff = wah_pkg::LEN_W'(wah_pkg::MAX_LENGTH);
    end else begin
      len_eff = cfg_wdata;
    end
    len_m1 = len_eff - wah_pkg::LEN_W'(1);
  end

  // One quotient bit per cycle, quotient shifts in behind the numerator
  assign trial = {rem_r, num_r[wah_pkg::QUOT_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign quot  = {num_r[wah_pkg::QUOT_W-2:0], ge};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wah_pkg::DIV_IDLE: begin
        if (start) state_nxt = wah_pkg::DIV_RUN;
      end
      wah_pkg::DIV_RUN: begin
        if (start)     state_nxt = wah_pkg::DIV_RUN;
        else if (last) state_nxt = wah_pkg::DIV_IDLE;
      end
      default: state_nxt = wah_pkg::DIV_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy = 1'b0;
    last = 1'b0;
    case (state_r)
      wah_pkg::DIV_IDLE: begin
        busy = 1'b0;
      end
      wah_pkg::DIV_RUN: begin
        busy = 1'b1;
        last = (cnt_r == '0);
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Divider datapath
  always_comb begin
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    cnt_nxt  = cnt_r;
    step_nxt = step_r;
    if (start) begin
      dvs_nxt = len_m1[wah_pkg::DIVR_W-1:0];
      rem_nxt = '0;
      num_nxt = (wah_pkg::QUOT_W'(1) << wah_pkg::STEP_W)
              + wah_pkg::QUOT_W'(len_m1 >> 1);
      cnt_nxt = wah_pkg::QCNT_W'(wah_pkg::QUOT_W - 1);
    end else if (busy) begin
      rem_nxt = ge ? wah_pkg::DIVR_W'(trial - {1'b0, dvs_r})
                   : trial[wah_pkg::DIVR_W-1:0];
      num_nxt = quot;
      cnt_nxt = cnt_r - wah_pkg::QCNT_W'(1);
      if (last) begin
        // saturate a step of one full turn
        step_nxt = quot[wah_pkg::QUOT_W-1] ? wah_pkg::STEP_MAX
                                           : quot[wah_pkg::STEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wah_pkg::DIV_IDLE;
      kind_r  <= wah_pkg::KIND_HANN;
      corr_r  <= 1'b0;
      step_r  <= wah_pkg::STEP_RESET;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we && (cfg_index == wah_pkg::REG_KIND)) kind_r <= cfg_wdata[0];
      if (cfg_we && (cfg_index == wah_pkg::REG_CORR)) corr_r <= cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
  end

  assign cfg.kind       = kind_r;
  assign cfg.corr       = corr_r;
  assign cfg.angle_step = step_r;

endmodule

`default_nettype wire

// File: src/wah_cos_rom.sv
// Full-turn cosine table with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module wah_cos_rom (
  input  wire logic                                 clk,
  input  wire logic                                 rd_en,
  input  wire logic [wah_pkg::COS_ADDR_BITS-1:0]    rd_addr,
  output logic signed [wah_pkg::COS_W-1:0]          rd_data
);

  logic signed [wah_pkg::COS_W-1:0] tbl [wah_pkg::COS_TABLE_DEPTH];
  logic signed [wah_pkg::COS_W-1:0] data_r;

  for (genvar k = 0; k < wah_pkg::COS_TABLE_DEPTH; k++) begin : g_tbl
    localparam logic signed [wah_pkg::COS_W-1:0] ENTRY = wah_pkg::cos_entry(k);
    assign tbl[k] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (rd_en) data_r <= tbl[rd_addr];
  end

  assign rd_data = data_r;

endmodule

`default_nettype wire

// File: src/wah_datapath.sv
// Six-stage elastic pipeline: phase, table read, coefficient, two products, round/saturate.
`timescale 1ns / 1ps
`default_nettype none

module wah_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire wah_pkg::cfg_t                         cfg,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [wah_pkg::SAMPLE_BITS-1:0] in_sample,
  input  wire logic [wah_pkg::IDX_W-1:0]             in_index,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [wah_pkg::SAMPLE_BITS-1:0]     out_sample,
  output logic                                       out_overflow
);

  localparam int NSTG = 6;
  localparam int PH_W = wah_pkg::IDX_W + wah_pkg::STEP_W;
  localparam int AB   = wah_pkg::COS_ADDR_BITS;

  logic [NSTG:1]   v_r;
  logic [NSTG+1:1] rdy;
  logic [NSTG:1]   ld;

  logic        [wah_pkg::STEP_W-1:0]          phase_r;
  logic signed [wah_pkg::SAMPLE_BITS-1:0]     smp1_r, smp2_r, smp3_r;
  logic signed [wah_pkg::COS_W-1:0]           cos_q;
  logic        [wah_pkg::COEF_W-1:0]          w_r;
  logic        [wah_pkg::GAIN_W-1:0]          g3_r, g4_r;
  logic signed [wah_pkg::PROD_W-1:0]          prod_r;
  logic signed [wah_pkg::TOTAL_W-1:0]         total_r;
  logic signed [wah_pkg::SAMPLE_BITS-1:0]     res_r;
  logic                                       ovf_r;

  logic [PH_W-1:0]                            ph_full;
  logic [wah_pkg::STEP_W:0]                   ph_rnd;
  logic [AB-1:0]                              rom_addr;
  logic [wah_pkg::COS_W-1:0]                  cu;
  logic [wah_pkg::COS_W+15-1:0]               hm_dd;
  logic [wah_pkg::COS_W-1:0]                  hm_rnd;
  logic [wah_pkg::COEF_W-1:0]                 w_nxt;
  logic [wah_pkg::GAIN_W-1:0]                 g_nxt;
  logic signed [wah_pkg::PROD_W+1:0]          prod_full;
  logic signed [wah_pkg::TOTAL_W:0]           total_full;
  logic signed [wah_pkg::TOTAL_W-1:0]         tot_rnd;
  logic signed [wah_pkg::RES_W-1:0]           res_full;
  logic signed [wah_pkg::SAMPLE_BITS-1:0]     res_nxt;
  logic                                       ovf_nxt;

  // A stage takes a word when it is empty or its own word moves on
  always_comb begin
    rdy[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ld[1] = rdy[1] && in_valid;
    for (int k = 2; k <= NSTG; k++) begin
      ld[k] = rdy[k] && v_r[k-1];
    end
  end

  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 1: phase as a fraction of a turn
  assign ph_full = PH_W'(in_index) * PH_W'(cfg.angle_step);

  // Stage 2: rounded table address, wrapped to one turn
  assign ph_rnd   = {1'b0, phase_r} + (wah_pkg::STEP_W'(1) << (wah_pkg::STEP_W - 1 - AB));
  assign rom_addr = ph_rnd[wah_pkg::STEP_W-1 -: AB];

  wah_cos_rom u_rom (
    .clk     (clk),
    .rd_en   (ld[2]),
    .rd_addr (rom_addr),
    .rd_data (cos_q)
  );

  // Stage 3: window coefficient and gain
  always_comb begin
    cu     = {~cos_q[wah_pkg::COS_W-1], cos_q[wah_pkg::COS_W-2:0]};  // cos + 1.0
    hm_dd  = (wah_pkg::COS_W + 15)'(wah_pkg::HAMMING_B) * (wah_pkg::COS_W + 15)'(cu);
    hm_rnd = wah_pkg::COS_W'((hm_dd + (wah_pkg::COS_W + 15)'(1 << 14)) >> 15);
    if (cfg.kind == wah_pkg::KIND_HANN) begin
      w_nxt = (wah_pkg::COEF_W'(1) << 16) - wah_pkg::COEF_W'(cu);
      g_nxt = cfg.corr ? wah_pkg::GAIN_HANN : wah_pkg::GAIN_UNITY;
    end else begin
      w_nxt = (wah_pkg::COEF_W'(1) << 16) - wah_pkg::COEF_W'(hm_rnd);
      g_nxt = cfg.corr ? wah_pkg::GAIN_HAMMING : wah_pkg::GAIN_UNITY;
    end
  end

  // Stage 4 and 5: sample times coefficient, then times gain
  assign prod_full  = $signed(smp3_r) * $signed({1'b0, w_r});
  assign total_full = prod_r * $signed({1'b0, g4_r});

  // Stage 6: round half up, then saturate
  always_comb begin
    tot_rnd  = total_r + wah_pkg::TOTAL_W'(1 << (wah_pkg::RES_SH - 1));
    res_full = wah_pkg::RES_W'(tot_rnd >>> wah_pkg::RES_SH);
    ovf_nxt  = 1'b0;
    res_nxt  = wah_pkg::SAMPLE_BITS'(res_full);
    if (res_full > wah_pkg::RES_W'(2 ** (wah_pkg::SAMPLE_BITS - 1) - 1)) begin
      res_nxt = {1'b0, {(wah_pkg::SAMPLE_BITS - 1){1'b1}}};
      ovf_nxt = 1'b1;
    end else if (res_full < -wah_pkg::RES_W'(2 ** (wah_pkg::SAMPLE_BITS - 1))) begin
      res_nxt = {1'b1, {(wah_pkg::SAMPLE_BITS - 1){1'b0}}};
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      phase_r <= ph_full[wah_pkg::STEP_W-1:0];
      smp1_r  <= in_sample;
    end
    if (ld[2]) begin
      smp2_r <= smp1_r;
    end
    if (ld[3]) begin
      w_r    <= w_nxt;
      g3_r   <= g_nxt;
      smp3_r <= smp2_r;
    end
    if (ld[4]) begin
      prod_r <= wah_pkg::PROD_W'(prod_full);
      g4_r   <= g3_r;
    end
    if (ld[5]) begin
      total_r <= wah_pkg::TOTAL_W'(total_full);
    end
    if (ld[6]) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_valid    = v_r[NSTG];
  assign out_sample   = res_r;
  assign out_overflow = ovf_r;

endmodule

`default_nettype wire

// File: src/window_apply_hann_hamming_top.sv
// Top level of the Hann/Hamming window block.
//
//  channel  dir  payload                              transfer
//  in_ch    in   sample[15:0], sample_index[9:0]      valid & ready
//  out_ch   out  windowed_sample[15:0], overflow       valid & ready
//  cfg_*    in   cfg_index[1:0], cfg_wdata[10:0]      cfg_we
//
// One word per cycle sustained while out_ch.ready stays high and no angle-step divide runs.
// Each stage holds its word while the next one cannot take it, so bubbles close under a stall.
// A window_length write runs a bit-serial divider for the angle step; in_ch.ready stays low
// while it runs. Reset is synchronous, active low, and loads the settings for a 1024-sample
// Hann window without correction; no table clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module window_apply_hann_hamming_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  wah_in_if.sink                                 in_ch,
  wah_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [wah_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wah_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  wah_pkg::cfg_t cfg;
  logic          busy;
  logic          dp_in_valid;
  logic          dp_in_ready;

  wah_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .busy      (busy)
  );

  // Hold off input while the angle step is being derived
  assign dp_in_valid = in_ch.valid && !busy;
  assign in_ch.ready = dp_in_ready && !busy;

  wah_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (dp_in_valid),
    .in_ready     (dp_in_ready),
    .in_sample    (in_ch.sample),
    .in_index     (in_ch.sample_index),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_sample   (out_ch.windowed_sample),
    .out_overflow (out_ch.overflow)
  );

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("input accepted while angle step divider is running");

  a_length_write_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == wah_pkg::REG_LENGTH)) |=> busy)
    else $error("length write did not start the divider");

  a_overflow_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.overflow) |->
      ((out_ch.windowed_sample == {1'b0, {(wah_pkg::SAMPLE_BITS - 1){1'b1}}}) ||
       (out_ch.windowed_sample == {1'b1, {(wah_pkg::SAMPLE_BITS - 1){1'b0}}})))
    else $error("overflow flagged on an unsaturated word");

endmodule

`default_nettype wire

// File: tb/tb_window_apply_hann_hamming_top.sv
// Self-checking testbench for the Hann/Hamming window block with a windowed-sample scoreboard.
`timescale 1ns / 1ps

module tb_window_apply_hann_hamming_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int WORDS_PER_PHASE = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [wah_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint HAMMING_SUM = 65536;  // 0.54 + 0.46 in Q0.16
  localparam longint SAT_HI = (longint'(1) <<< (wah_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< (wah_pkg::SAMPLE_BITS - 1));

  typedef struct packed {
    logic signed [wah_pkg::SAMPLE_BITS-1:0] sample;
    logic [wah_pkg::IDX_W-1:0]              sample_index;
    logic signed [wah_pkg::SAMPLE_BITS-1:0] windowed_sample;
    logic                                   overflow;
  } windowed_word_t;

  class window_scoreboard;
    logic signed [wah_pkg::COS_W-1:0] cos_q15 [wah_pkg::COS_TABLE_DEPTH];
    logic                             kind;
    logic                             corr;
    logic [wah_pkg::STEP_W-1:0]       step;
    windowed_word_t                   windowed_q[$];
    int                               errors;

    function new();
      for (int k = 0; k < wah_pkg::COS_TABLE_DEPTH; k++) cos_q15[k] = table_entry(k);
      kind   = wah_pkg::KIND_HANN;
      corr   = 1'b0;
      step   = step_for(wah_pkg::MAX_LENGTH);
      errors = 0;
    endfunction

    static function int effective_length(int len);
      if (len < 2) return 2;
      if (len > wah_pkg::MAX_LENGTH) return wah_pkg::MAX_LENGTH;
      return len;
    endfunction

    // cos((pi/2)*r/depth) in Q30 by a Taylor series through x^16
    function longint unsigned quarter_cos(longint unsigned r);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned sub;
      x  = QUARTER_TURN_Q30 * r / longint'(wah_pkg::COS_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int n = 8; n >= 1; n--) begin
        sub = ((x2 * t) >> 30) / longint'((2 * n - 1) * (2 * n));
        t   = (sub >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - sub;
      end
      return t;
    endfunction

    function longint unsigned to_q15(longint unsigned v);
      longint unsigned q;
      q = (v + (64'd1 << 14)) >> 15;
      return (q > 64'd32767) ? 64'd32767 : q;
    endfunction

    // mirror the first quadrant onto the full turn
    function logic signed [wah_pkg::COS_W-1:0] table_entry(int k);
      longint unsigned quadrant;
      longint unsigned r;
      longint unsigned near;
      longint unsigned far;
      quadrant = (4 * longint'(k)) / wah_pkg::COS_TABLE_DEPTH;
      r        = 4 * longint'(k) - quadrant * wah_pkg::COS_TABLE_DEPTH;
      near     = to_q15(quarter_cos(r));
      far      = to_q15(quarter_cos(wah_pkg::COS_TABLE_DEPTH - r));
      case (quadrant)
        0:       return wah_pkg::COS_W'(near);
        1:       return -wah_pkg::COS_W'(far);
        2:       return -wah_pkg::COS_W'(near);
        default: return wah_pkg::COS_W'(far);
      endcase
    endfunction

    function logic [wah_pkg::STEP_W-1:0] step_for(int len);
      longint q;
      longint span;
      span = effective_length(len) - 1;
      q = ((longint'(1) << wah_pkg::STEP_W) + span / 2) / span;
      return (q > longint'(wah_pkg::STEP_MAX)) ? wah_pkg::STEP_MAX : wah_pkg::STEP_W'(q);
    endfunction

    function void write_reg(logic [wah_pkg::CFG_IDX_W-1:0] ix,
                            logic [wah_pkg::CFG_DATA_W-1:0] d);
      case (ix)
        wah_pkg::REG_KIND:   kind = d[0];
        wah_pkg::REG_LENGTH: step = step_for(int'(d));
        wah_pkg::REG_CORR:   corr = d[0];
        default:    ;
      endcase
    endfunction

    function void note_sample(logic signed [wah_pkg::SAMPLE_BITS-1:0] s,
                              logic [wah_pkg::IDX_W-1:0] ix);
      logic [wah_pkg::IDX_W+wah_pkg::STEP_W-1:0] turn;
      longint addr;
      longint c;
      longint w;
      longint g;
      longint dd;
      longint res;
      windowed_word_t r;
      turn = ix * step;
      addr = ((longint'(turn[wah_pkg::STEP_W-1:0]) * wah_pkg::COS_TABLE_DEPTH
               + (longint'(1) << 23)) >> 24) % wah_pkg::COS_TABLE_DEPTH;
      c = cos_q15[addr];
      if (kind == wah_pkg::KIND_HANN) begin
        w = 32768 - c;
        g = corr ? longint'(wah_pkg::GAIN_HANN) : longint'(wah_pkg::GAIN_UNITY);
      end else begin
        dd = longint'(wah_pkg::HAMMING_B) * (c + 32768);
        w  = HAMMING_SUM - ((dd + 16384) >> 15);
        g  = corr ? longint'(wah_pkg::GAIN_HAMMING) : longint'(wah_pkg::GAIN_UNITY);
      end
      res = (longint'(s) * w * g + (longint'(1) << 29)) >>> 30;
      r.overflow = (res > SAT_HI) || (res < SAT_LO);
      if (res > SAT_HI) res = SAT_HI;
      if (res < SAT_LO) res = SAT_LO;
      r.sample          = s;
      r.sample_index    = ix;
      r.windowed_sample = wah_pkg::SAMPLE_BITS'(res);
      windowed_q.push_back(r);
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic signed [wah_pkg::SAMPLE_BITS-1:0] ws, logic ovf);
      windowed_word_t want;
      if (windowed_q.size() == 0) begin
        flag_mismatch($sformatf("result word %0d/%0b with no sample pending", ws, ovf));
      end else begin
        want = windowed_q.pop_front();
        if (ws !== want.windowed_sample)
          flag_mismatch($sformatf("sample %0d index %0d: windowed_sample %0d, want %0d",
                                  want.sample, want.sample_index, ws, want.windowed_sample));
        if (ovf !== want.overflow)
          flag_mismatch($sformatf("sample %0d index %0d: overflow %0b, want %0b",
                                  want.sample, want.sample_index, ovf, want.overflow));
      end
    endtask

    function int pending();
      return windowed_q.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [wah_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wah_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             send_idle_pct;
  int                             recv_idle_pct;

  window_scoreboard sb = new();

  wah_in_if  in_ch();
  wah_out_if out_ch();

  window_apply_hann_hamming_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mode 0: sender idles lightly, receiver heavily; mode 1: swapped; mode 2: no idling
  task automatic set_idle_mode(int mode);
    case (mode)
      0:       begin send_idle_pct = 18; recv_idle_pct = 63; end
      1:       begin send_idle_pct = 63; recv_idle_pct = 18; end
      default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  endtask

  task automatic send_word(logic signed [wah_pkg::SAMPLE_BITS-1:0] s,
                           logic [wah_pkg::IDX_W-1:0] ix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= s;
    in_ch.sample_index <= ix;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(s, ix);
  endtask

  // hold cfg_we high across back-to-back writes; the caller drops it
  task automatic put_reg(logic [wah_pkg::CFG_IDX_W-1:0] ix,
                         logic [wah_pkg::CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= ix;
    cfg_wdata <= d;
    @(posedge clk);
    sb.write_reg(ix, d);
  endtask

  // junk in the upper bits of the one-bit registers must be dropped
  task automatic apply_settings(logic kind, int len, logic corr);
    logic [wah_pkg::CFG_DATA_W-1:0] junk;
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    junk = wah_pkg::CFG_DATA_W'($urandom);
    put_reg(wah_pkg::REG_KIND, {junk[wah_pkg::CFG_DATA_W-1:1], kind});
    junk = wah_pkg::CFG_DATA_W'($urandom);
    put_reg(wah_pkg::REG_CORR, {junk[wah_pkg::CFG_DATA_W-1:1], corr});
    put_reg(REG_UNUSED, wah_pkg::CFG_DATA_W'($urandom));
    put_reg(wah_pkg::REG_LENGTH, wah_pkg::CFG_DATA_W'(len));
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [wah_pkg::SAMPLE_BITS-1:0] pick_sample();
    if ($urandom_range(9) >= 2) return wah_pkg::SAMPLE_BITS'($urandom);
    case ($urandom_range(4))
      0:       return wah_pkg::SAMPLE_BITS'(SAT_LO);
      1:       return wah_pkg::SAMPLE_BITS'(SAT_HI);
      2:       return '0;
      3:       return wah_pkg::SAMPLE_BITS'(-1);
      default: return wah_pkg::SAMPLE_BITS'(1);
    endcase
  endfunction

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.windowed_sample, out_ch.overflow);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int   dir_len [5];
    logic dir_kind [5];
    logic dir_corr [5];
    int   el;
    int   mid;
    int   len;
    int   frame_pos;
    int   pick;
    logic kind;
    logic corr;
    logic [wah_pkg::IDX_W-1:0] ix;

    dir_len  = '{wah_pkg::MAX_LENGTH, 2047, 0, 1, 3};
    dir_kind = '{wah_pkg::KIND_HANN, wah_pkg::KIND_HAMMING, wah_pkg::KIND_HANN,
                 wah_pkg::KIND_HAMMING, wah_pkg::KIND_HANN};
    dir_corr = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.sample       <= '0;
    in_ch.sample_index <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    set_idle_mode(0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings first, then clamped lengths and every kind/correction pair
    for (int d = 0; d < 5; d++) begin
      if (d > 0) apply_settings(dir_kind[d], dir_len[d], dir_corr[d]);
      el  = window_scoreboard::effective_length(dir_len[d]);
      mid = (el - 1) / 2;
      send_word(wah_pkg::SAMPLE_BITS'(SAT_HI), '0);
      send_word(wah_pkg::SAMPLE_BITS'(SAT_LO), wah_pkg::IDX_W'(mid));
      send_word(wah_pkg::SAMPLE_BITS'(SAT_HI), wah_pkg::IDX_W'(mid));
      send_word(wah_pkg::SAMPLE_BITS'(SAT_LO), wah_pkg::IDX_W'(el - 1));
      send_word((d % 2 == 0) ? wah_pkg::SAMPLE_BITS'(0) : wah_pkg::SAMPLE_BITS'(-1), '1);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       len = 2;
        1:       len = wah_pkg::MAX_LENGTH;
        2:       len = 3;
        3:       len = 2047;
        4:       len = 1;
        5:       len = wah_pkg::MAX_LENGTH + 1;
        default: len = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(2, 1024);
      endcase
      kind = (p < 4) ? p[0] : 1'($urandom);
      corr = (p < 4) ? p[1] : 1'($urandom);
      apply_settings(kind, len, corr);
      set_idle_mode(p * 3 / RANDOM_PHASES);
      el        = window_scoreboard::effective_length(len);
      frame_pos = 0;
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        // half walk whole frames, some are random in-frame picks, the rest random over the whole index range
        if (pick < 50) begin
          ix        = wah_pkg::IDX_W'(frame_pos);
          frame_pos = (frame_pos + 1 == el) ? 0 : frame_pos + 1;
        end else if (pick < 80) begin
          ix = wah_pkg::IDX_W'($urandom_range(el - 1));
        end else begin
          ix = wah_pkg::IDX_W'($urandom);
        end
        send_word(pick_sample(), ix);
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
